@@ rtl/tbmd5_pkg.sv @@
`timescale 1ns / 1ps

package tbmd5_pkg;

    localparam logic [31:0] START_EPOCH_RESET = 32'd1371517200;
    localparam logic [15:0] STEP_RESET        = 16'd30;
    localparam logic [30:0] PW_MODULUS        = 31'd100000000;
    localparam logic [4:0]  BCD_DIGITS        = 5'd20;

    localparam logic [1:0] CFG_START_EPOCH = 2'd0;
    localparam logic [1:0] CFG_STEP        = 2'd1;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_BUILD,
        ST_HASH_S,
        ST_HASH_T,
        ST_PICK,
        ST_MOD
    } state_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Characters of the fixed key text, in order.
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = 8'h67; 4'd1:  c = 8'h61; 4'd2:  c = 8'h33; 4'd3:  c = 8'h73;
            4'd4:  c = 8'h61; 4'd5:  c = 8'h34; 4'd6:  c = 8'h68; 4'd7:  c = 8'h6a;
            4'd8:  c = 8'h36; 4'd9:  c = 8'h6b; 4'd10: c = 8'h66; default: c = 8'h6c;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = 8'h30 + {4'd0, n};
        else
            c = 8'h37 + {4'd0, n};
        return c;
    endfunction

endpackage

@@ rtl/tbmd5_core.sv @@
`timescale 1ns / 1ps

module tbmd5_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [511:0] blk,
    output logic         done,
    output logic [127:0] digest
);

    logic [31:0]  a_reg, b_reg, c_reg, d_reg, t_reg;
    logic [5:0]   i_reg;
    logic         ph_reg, busy_reg, fin_reg, done_reg;
    logic [127:0] dig_reg;
    logic [31:0]  f, w;
    logic [3:0]   g;
    logic [63:0]  rot_wide;

    always_comb
    begin
        unique case (i_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = i_reg[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(5 * i_reg[3:0] + 1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * i_reg[3:0] + 5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * i_reg[3:0]);
            end
        endcase
        w = blk[{g, 5'd0} +: 32];
        rot_wide = {t_reg, t_reg} << tbmd5_pkg::md5_rot(i_reg);
    end

    // Each round sums the four terms, then rotates and adds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 1'b0;
            i_reg    <= 6'd0;
        end
        else
        begin
            done_reg <= !start && !busy_reg && fin_reg;
            if (start)
            begin
                a_reg    <= tbmd5_pkg::IV_A;
                b_reg    <= tbmd5_pkg::IV_B;
                c_reg    <= tbmd5_pkg::IV_C;
                d_reg    <= tbmd5_pkg::IV_D;
                i_reg    <= 6'd0;
                ph_reg   <= 1'b0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!ph_reg)
                begin
                    t_reg  <= a_reg + f + tbmd5_pkg::md5_k(i_reg) + w;
                    ph_reg <= 1'b1;
                end
                else
                begin
                    a_reg  <= d_reg;
                    d_reg  <= c_reg;
                    c_reg  <= b_reg;
                    b_reg  <= b_reg + rot_wide[63:32];
                    ph_reg <= 1'b0;
                    i_reg  <= i_reg + 6'd1;
                    if (i_reg == 6'd63)
                    begin
                        busy_reg <= 1'b0;
                        fin_reg  <= 1'b1;
                    end
                end
            end
            else if (fin_reg)
            begin
                dig_reg  <= {d_reg + tbmd5_pkg::IV_D, c_reg + tbmd5_pkg::IV_C,
                             b_reg + tbmd5_pkg::IV_B, a_reg + tbmd5_pkg::IV_A};
                fin_reg  <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign digest = dig_reg;

endmodule

@@ rtl/time_based_md5_password.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Signals                        Content
// s_*      in         tvalid tready tdata[127:0]     name bytes, code, current time
// m_*      out        tvalid tready tdata[31:0]      password
// cfg_*    in         valid ready index[1:0] data    start epoch, step seconds
//
// An item passes through decimal conversion of the code (the time division runs
// alongside), digit alignment, two MD5 runs on the single shared round unit, and
// a reduction of the picked window by repeated subtraction of the modulus.
// Reset restores the register defaults and returns the sequencer to idle.
// A finished password waits in the output register; the next word may be taken
// meanwhile, but the final step holds until the output register is free.

module time_based_md5_password
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // name_first0, name_first1, name_penult, name_final, device_code, now_seconds
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // password, zero padded
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    tbmd5_pkg::state_t state_reg, state_next;

    logic [31:0]  start_epoch_reg;
    logic [15:0]  step_reg;
    logic [7:0]   nf0_reg, nf1_reg, npen_reg, nfin_reg;
    logic [63:0]  bin_reg;
    logic [79:0]  bcd_reg;
    logic [79:0]  bcd_adj;
    logic [4:0]   nd_reg;
    logic [6:0]   cnt_reg;
    logic [31:0]  quo_reg;
    logic [16:0]  rem_reg;
    logic [15:0]  div_reg;
    logic [16:0]  rem_sh;
    logic [511:0] blk_reg;
    logic [511:0] sec_blk, time_blk;
    logic [127:0] sdig_reg;
    logic [127:0] tdig;
    logic [30:0]  val_reg;
    logic [30:0]  window;
    logic         m_valid_reg;
    logic [26:0]  pw_reg;
    logic         md_start, md_done;
    logic         in_fire, can_out;
    logic         pw_load;
    logic [511:0] mix;
    logic [3:0]   off;

    tbmd5_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .blk    (blk_reg),
        .done   (md_done),
        .digest (tdig)
    );

    assign in_fire = s_tvalid && s_tready;
    assign can_out = !m_valid_reg || m_tready;
    assign pw_load = (state_reg == tbmd5_pkg::ST_MOD) &&
                     (val_reg < tbmd5_pkg::PW_MODULUS) && can_out;

    always_comb
    begin
        for (int k = 0; k < 20; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
        rem_sh = {rem_reg[15:0], quo_reg[31]};
    end

    // Secret message block: bytes in order, then padding and the bit length.
    always_comb
    begin
        logic [5:0] q, r;
        logic [8:0] bitlen;
        sec_blk = '0;
        bitlen  = {6'd16 + {1'b0, nd_reg}, 3'd0};
        for (int p = 0; p < 64; p++)
        begin
            q = 6'(p - 8);
            r = q - {1'b0, nd_reg};
            if (p == 0)
                sec_blk[8*p +: 8] = nf0_reg;
            else if (p == 1)
                sec_blk[8*p +: 8] = nf1_reg;
            else if (p < 8)
                sec_blk[8*p +: 8] = tbmd5_pkg::key_char(4'(p - 2));
            else if (p == 56)
                sec_blk[8*p +: 8] = bitlen[7:0];
            else if (p == 57)
                sec_blk[8*p +: 8] = {7'd0, bitlen[8]};
            else if (q < {1'b0, nd_reg})
                sec_blk[8*p +: 8] = {4'h3, bcd_reg[7'd76 - {q[4:0], 2'd0} +: 4]};
            else if (r < 6'd6)
                sec_blk[8*p +: 8] = tbmd5_pkg::key_char(4'(r + 6'd6));
            else if (r == 6'd6)
                sec_blk[8*p +: 8] = npen_reg;
            else if (r == 6'd7)
                sec_blk[8*p +: 8] = nfin_reg;
            else if (r == 6'd8)
                sec_blk[8*p +: 8] = 8'h80;
        end
    end

    always_comb
    begin
        time_blk          = '0;
        time_blk[39:32]   = quo_reg[31:24];
        time_blk[47:40]   = quo_reg[23:16];
        time_blk[55:48]   = quo_reg[15:8];
        time_blk[63:56]   = quo_reg[7:0];
        time_blk[71:64]   = 8'h80;
        time_blk[455:448] = 8'h40;
    end

    // Interleave the two hex texts; only the first nineteen characters are ever windowed.
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            if (i[0] == 1'b0)
            begin
                mix[16*i +: 8]     = tbmd5_pkg::hex_char(sdig_reg[8*(i/2) + 4 +: 4]);
                mix[16*i + 8 +: 8] = tbmd5_pkg::hex_char(tdig[8*(i/2) + 4 +: 4]);
            end
            else
            begin
                mix[16*i +: 8]     = tbmd5_pkg::hex_char(sdig_reg[8*(i/2) +: 4]);
                mix[16*i + 8 +: 8] = tbmd5_pkg::hex_char(tdig[8*(i/2) +: 4]);
            end
        end
        off    = mix[507:504];
        window = {mix[{off, 3'd0} +: 7], mix[{off + 5'd1, 3'd0} +: 8],
                  mix[{off + 5'd2, 3'd0} +: 8], mix[{off + 5'd3, 3'd0} +: 8]};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbmd5_pkg::ST_IDLE:
                if (in_fire)
                    state_next = tbmd5_pkg::ST_CONV;
            tbmd5_pkg::ST_CONV:
                if (cnt_reg == 7'd63)
                    state_next = tbmd5_pkg::ST_NORM;
            tbmd5_pkg::ST_NORM:
                if (bcd_reg[79:76] != 4'd0 || nd_reg == 5'd1)
                    state_next = tbmd5_pkg::ST_BUILD;
            tbmd5_pkg::ST_BUILD:
                state_next = tbmd5_pkg::ST_HASH_S;
            tbmd5_pkg::ST_HASH_S:
                if (md_done)
                    state_next = tbmd5_pkg::ST_HASH_T;
            tbmd5_pkg::ST_HASH_T:
                if (md_done)
                    state_next = tbmd5_pkg::ST_PICK;
            tbmd5_pkg::ST_PICK:
                state_next = tbmd5_pkg::ST_MOD;
            tbmd5_pkg::ST_MOD:
                if (val_reg < tbmd5_pkg::PW_MODULUS && can_out)
                    state_next = tbmd5_pkg::ST_IDLE;
            default:
                state_next = tbmd5_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == tbmd5_pkg::ST_IDLE);
        md_start = (state_reg == tbmd5_pkg::ST_BUILD) ||
                   (state_reg == tbmd5_pkg::ST_HASH_S && md_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tbmd5_pkg::ST_IDLE;
            start_epoch_reg <= tbmd5_pkg::START_EPOCH_RESET;
            step_reg        <= tbmd5_pkg::STEP_RESET;
            m_valid_reg     <= 1'b0;
            cnt_reg         <= 7'd0;
            nd_reg          <= tbmd5_pkg::BCD_DIGITS;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == tbmd5_pkg::CFG_START_EPOCH)
                    start_epoch_reg <= cfg_data;
                else if (cfg_index == tbmd5_pkg::CFG_STEP)
                    step_reg <= cfg_data[15:0];
            end
            if (m_valid_reg && m_tready && !pw_load)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                tbmd5_pkg::ST_IDLE:
                    if (in_fire)
                    begin
                        nf0_reg  <= s_tdata[7:0];
                        nf1_reg  <= s_tdata[15:8];
                        npen_reg <= s_tdata[23:16];
                        nfin_reg <= s_tdata[31:24];
                        bin_reg  <= s_tdata[95:32];
                        bcd_reg  <= '0;
                        quo_reg  <= s_tdata[127:96] - start_epoch_reg;
                        rem_reg  <= '0;
                        div_reg  <= (step_reg == 16'd0) ? 16'd1 : step_reg;
                        cnt_reg  <= 7'd0;
                        nd_reg   <= tbmd5_pkg::BCD_DIGITS;
                    end
                tbmd5_pkg::ST_CONV:
                begin
                    {bcd_reg, bin_reg} <= {bcd_adj, bin_reg} << 1;
                    if (cnt_reg < 7'd32)
                    begin
                        if (rem_sh >= {1'b0, div_reg})
                        begin
                            rem_reg <= rem_sh - {1'b0, div_reg};
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                end
                tbmd5_pkg::ST_NORM:
                    if (bcd_reg[79:76] == 4'd0 && nd_reg != 5'd1)
                    begin
                        bcd_reg <= {bcd_reg[75:0], 4'd0};
                        nd_reg  <= nd_reg - 5'd1;
                    end
                tbmd5_pkg::ST_BUILD:
                    blk_reg <= sec_blk;
                tbmd5_pkg::ST_HASH_S:
                    if (md_done)
                    begin
                        sdig_reg <= tdig;
                        blk_reg  <= time_blk;
                    end
                tbmd5_pkg::ST_HASH_T:
                    ;
                tbmd5_pkg::ST_PICK:
                    val_reg <= window;
                tbmd5_pkg::ST_MOD:
                    if (val_reg >= tbmd5_pkg::PW_MODULUS)
                        val_reg <= val_reg - tbmd5_pkg::PW_MODULUS;
                    else if (can_out)
                    begin
                        pw_reg      <= val_reg[26:0];
                        m_valid_reg <= 1'b1;
                    end
                default:
                    ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, pw_reg};

endmodule

@@ tb/tb_time_based_md5_password.sv @@
`timescale 1ns / 1ps

module tb_time_based_md5_password;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // name_first0, name_first1, name_penult, name_final, device_code, now_seconds
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // password, zero padded
    logic [31:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    typedef struct {
        logic [7:0]  first0;
        logic [7:0]  first1;
        logic [7:0]  penult;
        logic [7:0]  last;
        logic [63:0] code;
        logic [31:0] now;
    } login_t;

    logic [31:0] epoch_shadow;
    logic [15:0] step_shadow;
    logic [26:0] pending_pw[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          checked;
    int          words_sent;

    time_based_md5_password dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // Single-block MD5 of up to 55 bytes, returned as 32 uppercase hex characters.
    function automatic void md5_text(input logic [7:0] msg[64], input int len,
                                     output logic [7:0] hex[32]);
        logic [7:0]  blk[64];
        logic [31:0] w[16];
        logic [31:0] st[4];
        logic [31:0] a, b, c, d, f, tmp;
        logic [63:0] bits;
        logic [7:0]  bt;
        logic [3:0]  nib;
        int          g;
        int          rot[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] kt[64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
            32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
            32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
            32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
            32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
            32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
            32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
            32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
            32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        for (int i = 0; i < 64; i++)
            blk[i] = (i < len) ? msg[i] : 8'h00;
        blk[len] = 8'h80;
        bits = 64'(len) * 8;
        for (int i = 0; i < 8; i++)
            blk[56 + i] = bits[8*i +: 8];
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        st = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        a = st[0]; b = st[1]; c = st[2]; d = st[3];
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)      begin f = (b & c) | (~b & d); g = i;              end
            else if (i < 32) begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
            else if (i < 48) begin f = b ^ c ^ d;          g = (3*i + 5) % 16; end
            else             begin f = c ^ (b | ~d);       g = (7*i) % 16;     end
            tmp = d; d = c; c = b;
            b = b + rotl(a + f + kt[i] + w[g], rot[((i / 16) * 4) + (i % 4)]);
            a = tmp;
        end
        st[0] += a; st[1] += b; st[2] += c; st[3] += d;
        for (int i = 0; i < 16; i++)
        begin
            bt = st[i / 4][8*(i % 4) +: 8];
            nib = bt[7:4];
            hex[2*i] = (nib < 10) ? 8'h30 + nib : 8'h37 + nib;
            nib = bt[3:0];
            hex[2*i+1] = (nib < 10) ? 8'h30 + nib : 8'h37 + nib;
        end
    endfunction

    function automatic logic [26:0] predict_password(input login_t x);
        logic [7:0]  secret[64];
        logic [7:0]  tmsg[64];
        logic [7:0]  sh[32];
        logic [7:0]  th[32];
        logic [7:0]  mix[64];
        logic [7:0]  digits[20];
        logic [7:0]  key[12] = '{"g", "a", "3", "s", "a", "4", "h", "j", "6", "k", "f", "l"};
        logic [63:0] code;
        logic [31:0] elapsed, steps, win;
        int          n, nd, off;
        n = 0;
        nd = 0;
        code = x.code;
        foreach (secret[i]) secret[i] = 8'h00;
        foreach (tmsg[i]) tmsg[i] = 8'h00;
        secret[n++] = x.first0;
        secret[n++] = x.first1;
        for (int i = 0; i < 6; i++) secret[n++] = key[i];
        do
        begin
            digits[nd++] = 8'h30 + 8'(code % 10);
            code = code / 10;
        end while (code != 0);
        while (nd > 0) secret[n++] = digits[--nd];
        for (int i = 6; i < 12; i++) secret[n++] = key[i];
        secret[n++] = x.penult;
        secret[n++] = x.last;
        elapsed = x.now - epoch_shadow;
        steps = elapsed / ((step_shadow == 0) ? 32'd1 : {16'd0, step_shadow});
        for (int i = 0; i < 4; i++) tmsg[7 - i] = steps[8*i +: 8];
        md5_text(secret, n, sh);
        md5_text(tmsg, 8, th);
        for (int i = 0; i < 32; i++)
        begin
            mix[2*i] = sh[i];
            mix[2*i+1] = th[i];
        end
        off = mix[63][3:0];
        win = {1'b0, mix[off][6:0], mix[off+1], mix[off+2], mix[off+3]};
        return 27'(win % 100000000);
    endfunction

    task automatic tick_wait();
        @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do tick_wait(); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == tbmd5_pkg::CFG_START_EPOCH) epoch_shadow = value;
        else step_shadow = value[15:0];
        tick_wait();
    endtask

    task automatic send_login(input login_t x);
        while ($urandom_range(99) < send_idle_pct) tick_wait();
        pending_pw.push_back(predict_password(x));
        s_tvalid <= 1'b1;
        s_tdata  <= {x.now, x.code, x.last, x.penult, x.first1, x.first0};
        do tick_wait(); while (!s_tready);
        s_tvalid <= 1'b0;
        words_sent++;
        tick_wait();
    endtask

    // Waits for every password to come back, then allows the block to settle.
    task automatic drain();
        while (pending_pw.size() != 0) tick_wait();
        repeat (400) tick_wait();
    endtask

    function automatic login_t random_login();
        login_t x;
        x.first0 = 8'($urandom); x.first1 = 8'($urandom);
        x.penult = 8'($urandom); x.last = 8'($urandom);
        case ($urandom_range(3))
            0: x.code = 64'($urandom_range(999));
            1: x.code = {32'd0, 32'($urandom)};
            default: x.code = {32'($urandom), 32'($urandom)};
        endcase
        x.now = $urandom;
        return x;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_pw.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected password word %0d", m_tdata);
                end
                else
                begin
                    logic [26:0] want;
                    want = pending_pw.pop_front();
                    checked++;
                    if (m_tdata != {5'd0, want})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("password mismatch: expected %0d, got %0d", want, m_tdata);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        login_t x;
        x = '{8'h00, 8'h00, 8'h00, 8'h00, 64'd0, 32'd1371517200};
        send_login(x);
        x = '{8'hff, 8'hff, 8'hff, 8'hff, 64'hffffffffffffffff, 32'hffffffff};
        send_login(x);
        // Time before the start epoch wraps to a large step count.
        x = '{8'h41, 8'h42, 8'h59, 8'h5a, 64'd9, 32'd0};
        send_login(x);
        x = '{8'h80, 8'h01, 8'h7f, 8'hfe, 64'd10, 32'd1371517229};
        send_login(x);
        x = '{8'h55, 8'haa, 8'h33, 8'hcc, 64'd10000000000000000000, 32'd1371517230};
        send_login(x);
        x = '{8'h30, 8'h31, 8'h32, 8'h33, 64'd1234567890, 32'h80000000};
        send_login(x);
        drain();
    endtask

    task automatic test_registers();
        login_t x;
        write_register(tbmd5_pkg::CFG_STEP, 32'd0);
        write_register(tbmd5_pkg::CFG_START_EPOCH, 32'd0);
        for (int i = 0; i < 4; i++) send_login(random_login());
        drain();
        write_register(tbmd5_pkg::CFG_STEP, 32'd65535);
        write_register(tbmd5_pkg::CFG_START_EPOCH, 32'hffffffff);
        x = '{8'h01, 8'h02, 8'h03, 8'h04, 64'd77, 32'd0};
        send_login(x);
        for (int i = 0; i < 4; i++) send_login(random_login());
        drain();
        write_register(tbmd5_pkg::CFG_STEP, 32'd1);
        for (int i = 0; i < 4; i++) send_login(random_login());
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                drain();
                write_register(tbmd5_pkg::CFG_START_EPOCH, $urandom);
                write_register(tbmd5_pkg::CFG_STEP, $urandom_range(65535));
            end
            send_login(random_login());
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        epoch_shadow = tbmd5_pkg::START_EPOCH_RESET;
        step_shadow = tbmd5_pkg::STEP_RESET;
        mismatches = 0;
        checked = 0;
        words_sent = 0;
        send_idle_pct = 17;
        recv_idle_pct = 61;
        repeat (10) tick_wait();
        rst_n <= 1'b1;
        tick_wait();
        test_directed();
        test_registers();
        test_random(130);
        send_idle_pct = 61;
        recv_idle_pct = 17;
        test_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(130);
        $display("Sent %0d login words and checked %0d passwords", words_sent, checked);
        $display("over several epoch and step settings and three handshake patterns.");
        if (mismatches == 0 && pending_pw.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
